// ===== hdl/image_upscale_2x_macros.svh =====
// Assertion macros for the image upscaler.
`ifndef IMAGE_UPSCALE_2X_MACROS_SVH
`define IMAGE_UPSCALE_2X_MACROS_SVH
`ifndef SYNTHESIS
`define UPX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("upscaler check failed");
`define UPX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("upscaler check failed");
`else
`define UPX_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define UPX_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/upx_pkg.sv =====
`timescale 1ns / 1ps
package upx_pkg;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int LINES_KEPT     = 4;
   localparam int CFG_W          = 11;
   localparam int CRD_W          = 14;
   localparam int PIX_W          = 8;
   localparam int VAL_W          = 18;
   localparam int OUT_W          = 11;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [1:0] MODE_NEAREST  = 2'd0;
   localparam logic [1:0] MODE_BILINEAR = 2'd1;
   localparam logic [1:0] MODE_BICUBIC  = 2'd2;

   typedef logic signed [CRD_W-1:0] crd_type;

   typedef struct packed {
      crd_type    i0;
      crd_type    i1;
      crd_type    j0;
      crd_type    j1;
      crd_type    h;
      crd_type    w;
      logic [1:0] mode;
   } upx_job_type;

   function automatic logic signed [4:0] tap(input logic [1:0] k);
      tap = (k == 2'd0 || k == 2'd3) ? -5'sd1 : 5'sd9;
   endfunction

   function automatic crd_type clamp(input crd_type v, input crd_type hi);
      if (v < 0) begin
         clamp = '0;
      end else if (v > hi) begin
         clamp = hi;
      end else begin
         clamp = v;
      end
   endfunction
endpackage

// ===== hdl/upx_line_mem.sv =====
`timescale 1ns / 1ps
module upx_line_mem import upx_pkg::*; #(
   parameter int DEPTH = LINES_KEPT * MAX_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [PIX_W-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [PIX_W-1:0] rdata
);
   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/upx_core.sv =====
`timescale 1ns / 1ps
`include "image_upscale_2x_macros.svh"
module upx_core import upx_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int AW        = $clog2(LINES_KEPT * MAX_WIDTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  upx_job_type             job,
   output logic                    idle,
   output logic [AW-1:0]           raddr,
   input  logic [PIX_W-1:0]        rdata,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_W-1:0]        rsp_out_row,
   output logic [OUT_W-1:0]        rsp_out_col,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic                    rsp_last
);
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RD    = 4'b0010,
      S_DRAIN = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   localparam logic [AW-1:0] STRIDE = AW'(MAX_WIDTH);

   state_type                state_ff, state_in;
   upx_job_type              job_ff, job_in;
   crd_type                  i_ff, i_in, j_ff, j_in;
   logic [1:0]               a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic [1:0]               ta_ff, tb_ff;
   logic                     rv_ff, rv_in;
   logic signed [VAL_W-1:0]  accr_ff, accr_in, accd_ff, accd_in, accg_ff, accg_in;
   logic [PIX_W-1:0]         p_ff, p_in;
   logic                     ov_ff, ov_in;
   logic [OUT_W-1:0]         orow_ff, orow_in, ocol_ff, ocol_in;
   logic signed [VAL_W-1:0]  oval_ff, oval_in;
   logic                     olast_ff, olast_in;

   logic [1:0]               lo, hi, lo_new;
   crd_type                  srow, scol;
   logic signed [4:0]        wa, wb;
   logic signed [VAL_W-1:0]  s, ws_b, ws_a, wab;
   logic                     load, last_pos, empty;
   logic signed [VAL_W-1:0]  p256, vsel;

   assign lo     = (job_ff.mode == MODE_NEAREST || job_ff.mode == MODE_BILINEAR) ? 2'd1 : 2'd0;
   assign hi     = (job_ff.mode == MODE_NEAREST) ? 2'd1 :
                   (job_ff.mode == MODE_BILINEAR) ? 2'd2 : 2'd3;
   assign lo_new = (job.mode == MODE_NEAREST || job.mode == MODE_BILINEAR) ? 2'd1 : 2'd0;
   assign empty  = (job.i1 < job.i0) || (job.j1 < job.j0);

   assign srow  = clamp(i_ff + crd_type'(a_ff) - crd_type'(1), job_ff.h - crd_type'(1));
   assign scol  = clamp(j_ff + crd_type'(b_ff) - crd_type'(1), job_ff.w - crd_type'(1));
   assign raddr = AW'(srow[1:0]) * STRIDE + AW'(scol[CRD_W-2:0]);

   assign wa   = job_ff.mode[1] ? tap(ta_ff) : 5'sd1;
   assign wb   = job_ff.mode[1] ? tap(tb_ff) : 5'sd1;
   assign s    = VAL_W'(signed'({1'b0, rdata}));
   assign ws_b = VAL_W'(wb * s);
   assign ws_a = VAL_W'(wa * s);
   assign wab  = VAL_W'(wa * ws_b);

   assign load     = !ov_ff || rsp_ready;
   assign last_pos = (i_ff == job_ff.i1) && (j_ff == job_ff.j1);
   assign p256     = VAL_W'(signed'({1'b0, p_ff, 8'd0}));

   always_comb begin
      unique case (k_ff)
         2'd0: vsel = p256;
         2'd1: vsel = (job_ff.mode == MODE_NEAREST) ? p256 :
                      (job_ff.mode == MODE_BILINEAR) ? accr_ff <<< 7 : accr_ff <<< 4;
         2'd2: vsel = (job_ff.mode == MODE_NEAREST) ? p256 :
                      (job_ff.mode == MODE_BILINEAR) ? accd_ff <<< 7 : accd_ff <<< 4;
         default: vsel = (job_ff.mode == MODE_NEAREST) ? p256 :
                         (job_ff.mode == MODE_BILINEAR) ? accg_ff <<< 6 : accg_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      rv_in    = 1'b0;
      accr_in  = accr_ff;
      accd_in  = accd_ff;
      accg_in  = accg_ff;
      p_in     = p_ff;
      ov_in    = ov_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      oval_in  = oval_ff;
      olast_in = olast_ff;

      if (rv_ff) begin
         accg_in = accg_ff + wab;
         if (ta_ff == 2'd1) begin
            accr_in = accr_ff + ws_b;
         end
         if (tb_ff == 2'd1) begin
            accd_in = accd_ff + ws_a;
         end
         if (ta_ff == 2'd1 && tb_ff == 2'd1) begin
            p_in = rdata;
         end
      end

      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start && !empty) begin
               job_in   = job;
               i_in     = job.i0;
               j_in     = job.j0;
               a_in     = lo_new;
               b_in     = lo_new;
               accr_in  = '0;
               accd_in  = '0;
               accg_in  = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            rv_in = 1'b1;
            if (b_ff == hi) begin
               b_in = lo;
               if (a_ff == hi) begin
                  state_in = S_DRAIN;
               end else begin
                  a_in = a_ff + 2'd1;
               end
            end else begin
               b_in = b_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            k_in     = 2'd0;
            state_in = S_EMIT;
         end
         default: begin
            if (load) begin
               ov_in    = 1'b1;
               orow_in  = OUT_W'({i_ff, 1'b0}) | OUT_W'(k_ff[1]);
               ocol_in  = OUT_W'({j_ff, 1'b0}) | OUT_W'(k_ff[0]);
               oval_in  = vsel;
               olast_in = (k_ff == 2'd3) && last_pos;
               k_in     = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  if (last_pos) begin
                     state_in = S_IDLE;
                  end else begin
                     if (j_ff == job_ff.j1) begin
                        j_in = job_ff.j0;
                        i_in = i_ff + crd_type'(1);
                     end else begin
                        j_in = j_ff + crd_type'(1);
                     end
                     a_in     = lo;
                     b_in     = lo;
                     accr_in  = '0;
                     accd_in  = '0;
                     accg_in  = '0;
                     state_in = S_RD;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         ov_ff    <= ov_in;
      end
      job_ff   <= job_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      ta_ff    <= a_ff;
      tb_ff    <= b_ff;
      accr_ff  <= accr_in;
      accd_ff  <= accd_in;
      accg_ff  <= accg_in;
      p_ff     <= p_in;
      orow_ff  <= orow_in;
      ocol_ff  <= ocol_in;
      oval_ff  <= oval_in;
      olast_ff <= olast_in;
   end

   assign idle        = (state_ff == S_IDLE);
   assign rsp_valid   = ov_ff;
   assign rsp_out_row = orow_ff;
   assign rsp_out_col = ocol_ff;
   assign rsp_value   = oval_ff;
   assign rsp_last    = olast_ff;

   `UPX_ASSERT_IMP(a_start_idle, clock, reset, start, state_ff == S_IDLE)
   `UPX_ASSERT_IMP(a_read_tag, clock, reset, rv_ff, $past(state_ff == S_RD))
   `UPX_ASSERT_NXT(a_last_done, clock, reset,
      state_ff == S_EMIT && load && k_ff == 2'd3 && last_pos, state_ff == S_IDLE && rsp_last)
endmodule

// ===== hdl/image_upscale_2x.sv =====
`timescale 1ns / 1ps
// Streaming 2x upscaler for 8-bit pixels in raster order, with nearest, bilinear and
// bicubic (Catmull-Rom) modes and edge clamping. Source pixels are kept in a line
// memory of four rows of MAX_WIDTH bytes with one write and one registered read port;
// there is no clearing pass. For each source position that an item completes, the core
// performs N line memory reads for its window (1 nearest, 4 bilinear, 16 bicubic),
// read one per cycle, followed by a drain state and four results, which stall while
// rsp_ready is low. An item that completes no position produces no results. The last
// result of an item carries rsp_last.
// A write to the mode, width or height register restarts the frame at position (0,0).
module image_upscale_2x import upx_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIX_W-1:0]        req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_W-1:0]        rsp_out_row,
   output logic [OUT_W-1:0]        rsp_out_col,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);
   localparam int DEPTH = LINES_KEPT * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] STRIDE = AW'(MAX_WIDTH);

   logic [1:0]       mode_ff, mode_in;
   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   crd_type          row_ff, row_in, col_ff, col_in;
   crd_type          w_eff, h_eff, lag, rl, cl;
   logic             accept, idle;
   upx_job_type      job;
   logic [AW-1:0]    waddr, raddr;
   logic [PIX_W-1:0] rdata;

   assign w_eff = (width_ff == '0) ? crd_type'(1) :
                  (crd_type'(width_ff) > crd_type'(MAX_WIDTH)) ? crd_type'(MAX_WIDTH) :
                  crd_type'(width_ff);
   assign h_eff = (height_ff == '0) ? crd_type'(1) :
                  (crd_type'(height_ff) > crd_type'(MAX_HEIGHT)) ? crd_type'(MAX_HEIGHT) :
                  crd_type'(height_ff);
   assign lag   = (mode_ff == MODE_NEAREST) ? crd_type'(0) :
                  (mode_ff == MODE_BILINEAR) ? crd_type'(1) : crd_type'(2);

   assign req_ready = idle;
   assign accept    = req_valid && idle;

   assign rl       = row_ff - lag;
   assign cl       = col_ff - lag;
   assign job.i1   = (row_ff == h_eff - crd_type'(1)) ? h_eff - crd_type'(1) : rl;
   assign job.i0   = (rl < 0) ? crd_type'(0) : rl;
   assign job.j1   = (col_ff == w_eff - crd_type'(1)) ? w_eff - crd_type'(1) : cl;
   assign job.j0   = (cl < 0) ? crd_type'(0) : cl;
   assign job.h    = h_eff;
   assign job.w    = w_eff;
   assign job.mode = mode_ff;

   assign waddr = AW'(row_ff[1:0]) * STRIDE + AW'(col_ff[CRD_W-2:0]);

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (accept) begin
         if (col_ff >= w_eff - crd_type'(1)) begin
            col_in = '0;
            row_in = (row_ff >= h_eff - crd_type'(1)) ? crd_type'(0) : row_ff + crd_type'(1);
         end else begin
            col_in = col_ff + crd_type'(1);
         end
      end
      if (csr_we) begin
         unique case (csr_index)
            REG_MODE: begin
               mode_in = csr_wdata[1:0];
               row_in  = '0;
               col_in  = '0;
            end
            REG_WIDTH: begin
               width_in = csr_wdata;
               row_in   = '0;
               col_in   = '0;
            end
            REG_HEIGHT: begin
               height_in = csr_wdata;
               row_in    = '0;
               col_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BICUBIC;
         width_ff  <= CFG_W'(1024);
         height_ff <= CFG_W'(1024);
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

   upx_line_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock (clock),
      .we    (accept),
      .waddr (waddr),
      .wdata (req_pixel),
      .raddr (raddr),
      .rdata (rdata)
   );

   upx_core #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .job         (job),
      .idle        (idle),
      .raddr       (raddr),
      .rdata       (rdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last)
   );
endmodule

// ===== verif/tb_image_upscale_2x.sv =====
`timescale 1ns / 1ps
module tb_image_upscale_2x;
   import upx_pkg::*;

   localparam logic [1:0] REG_SPARE    = 2'd3;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE      = 60;

   typedef struct {
      logic [OUT_W-1:0]        row;
      logic [OUT_W-1:0]        col;
      logic signed [VAL_W-1:0] val;
      logic                    last;
   } upscaled_pel_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [PIX_W-1:0]        req_pixel;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [OUT_W-1:0]        rsp_out_row;
   logic [OUT_W-1:0]        rsp_out_col;
   logic signed [VAL_W-1:0] rsp_value;
   logic                    rsp_last;
   logic                    csr_we;
   logic [1:0]              csr_index;
   logic [CFG_W-1:0]        csr_wdata;

   upscaled_pel_type upscaled_q[$];
   logic [7:0]    pel_store[4][1024];
   int            src_row, src_col;
   logic [1:0]    cur_mode;
   logic [10:0]   cur_width, cur_height;
   int            mismatches = 0;
   int            pixels_sent;
   int            idle_cnt;
   bit            quiet_send, quiet_recv;

   image_upscale_2x u_dut (.*);

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int eff_dim(logic [10:0] v);
      if (v == 0) return 1;
      if (v > 1024) return 1024;
      return int'(v);
   endfunction

   function automatic int pel_at(int a, int b, int h, int w);
      if (a < 0) a = 0;
      if (a > h - 1) a = h - 1;
      if (b < 0) b = 0;
      if (b > w - 1) b = w - 1;
      return int'(pel_store[a % 4][b]);
   endfunction

   function automatic int tap_w(int k);
      return (k == 0 || k == 3) ? -1 : 9;
   endfunction

   function automatic void push_pel(int r, int c, int v);
      upscaled_pel_type e;
      e.row  = r[10:0];
      e.col  = c[10:0];
      e.val  = v[17:0];
      e.last = 1'b0;
      upscaled_q.push_back(e);
   endfunction

   task automatic upscale_pixel(input logic [7:0] px);
      int w, h, r, c, lag, i0, i1, j0, j1, p, vr, vd, vg, n;
      w = eff_dim(cur_width);
      h = eff_dim(cur_height);
      r = (src_row > h - 1) ? h - 1 : src_row;
      c = (src_col > w - 1) ? w - 1 : src_col;
      pel_store[r % 4][c] = px;
      lag = (cur_mode == MODE_NEAREST) ? 0 : (cur_mode == MODE_BILINEAR) ? 1 : 2;
      i0 = (r - lag < 0) ? 0 : r - lag;
      i1 = (r == h - 1) ? h - 1 : r - lag;
      j0 = (c - lag < 0) ? 0 : c - lag;
      j1 = (c == w - 1) ? w - 1 : c - lag;
      n = 0;
      for (int i = i0; i <= i1; i++) begin
         for (int j = j0; j <= j1; j++) begin
            p = pel_at(i, j, h, w);
            if (cur_mode == MODE_NEAREST) begin
               vr = p * 256; vd = vr; vg = vr;
            end else if (cur_mode == MODE_BILINEAR) begin
               vr = (p + pel_at(i, j + 1, h, w)) * 128;
               vd = (p + pel_at(i + 1, j, h, w)) * 128;
               vg = (p + pel_at(i, j + 1, h, w) + pel_at(i + 1, j, h, w)
                     + pel_at(i + 1, j + 1, h, w)) * 64;
            end else begin
               vr = 0; vd = 0; vg = 0;
               for (int a = 0; a < 4; a++) begin
                  vr += tap_w(a) * pel_at(i, j + a - 1, h, w);
                  vd += tap_w(a) * pel_at(i + a - 1, j, h, w);
                  for (int b = 0; b < 4; b++) begin
                     vg += tap_w(a) * tap_w(b) * pel_at(i + a - 1, j + b - 1, h, w);
                  end
               end
               vr *= 16;
               vd *= 16;
            end
            push_pel(2 * i, 2 * j, p * 256);
            push_pel(2 * i, 2 * j + 1, vr);
            push_pel(2 * i + 1, 2 * j, vd);
            push_pel(2 * i + 1, 2 * j + 1, vg);
            n += 4;
         end
      end
      if (n > 0) upscaled_q[upscaled_q.size() - 1].last = 1'b1;
      if (c >= w - 1) begin
         src_col = 0;
         src_row = (r >= h - 1) ? 0 : r + 1;
      end else begin
         src_col = c + 1;
         src_row = r;
      end
   endtask

   task automatic send_pixel(input logic [7:0] px);
      int gap;
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      upscale_pixel(px);
      pixels_sent++;
      gap = quiet_send ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (upscaled_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_MODE: begin
            cur_mode = data[1:0];
         end
         REG_WIDTH: begin
            cur_width = data;
         end
         REG_HEIGHT: begin
            cur_height = data;
         end
         default: begin
         end
      endcase
      if (idx != REG_SPARE) begin
         src_row = 0;
         src_col = 0;
      end
   endtask

   task automatic setup(input logic [1:0] m, input logic [10:0] w, input logic [10:0] h);
      write_reg(REG_MODE, {9'd0, m});
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   // Tiny frames of full-scale black and white pixels in every mode.
   task automatic test_modes_extremes();
      logic [1:0] m;
      for (int k = 0; k < 4; k++) begin
         m = k[1:0];
         setup(m, 11'd2, 11'd2);
         send_pixel(8'd0);
         send_pixel(8'd255);
         send_pixel(8'd255);
         send_pixel(8'd0);
      end
   endtask

   // Zero and oversized dimensions, and a write to the unused index.
   task automatic test_dim_limits();
      setup(MODE_NEAREST, 11'd0, 11'd0);
      send_pixel(8'd255);
      send_pixel(8'd1);
      setup(MODE_BICUBIC, 11'd2047, 11'd1);
      for (int k = 0; k < 5; k++) send_pixel(k[0] ? 8'd255 : 8'd0);
      setup(MODE_BILINEAR, 11'd1, 11'd2047);
      send_pixel(8'd128);
      send_pixel(8'd127);
      write_reg(REG_SPARE, 11'h7ff);
      send_pixel(8'd255);
      send_pixel(8'd0);
   endtask

   task automatic test_random_frames();
      int w, h, frames, cut;
      while (pixels_sent < 200) begin
         quiet_send = ($urandom_range(0, 4) == 0);
         quiet_recv = ($urandom_range(0, 4) == 0);
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         setup(2'($urandom_range(0, 3)), 11'(w), 11'(h));
         frames = $urandom_range(1, 2);
         for (int f = 0; f < frames; f++) begin
            for (int k = 0; k < w * h; k++) send_pixel(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_SPARE, 11'($urandom_range(0, 2047)));
            send_pixel(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, w * h);
            for (int k = 0; k < cut; k++) send_pixel(8'($urandom_range(0, 255)));
         end
      end
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
   endtask

   always begin
      int stall;
      upscaled_pel_type e;
      stall = quiet_recv ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
         rsp_ready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_ready <= 1'b1;
      do @(posedge clock); while (!(rsp_valid && rsp_ready && !reset));
      if (upscaled_q.size() == 0) begin
         $display("%0t unexpected result row %0d col %0d value %0d last %0b", $time,
                  rsp_out_row, rsp_out_col, rsp_value, rsp_last);
         mismatches++;
      end else begin
         e = upscaled_q.pop_front();
         if (rsp_out_row !== e.row) begin
            $display("%0t out_row expected %0d actual %0d", $time, e.row, rsp_out_row);
            mismatches++;
         end
         if (rsp_out_col !== e.col) begin
            $display("%0t out_col expected %0d actual %0d", $time, e.col, rsp_out_col);
            mismatches++;
         end
         if (rsp_value !== e.val) begin
            $display("%0t value expected %0d actual %0d", $time, e.val, rsp_value);
            mismatches++;
         end
         if (rsp_last !== e.last) begin
            $display("%0t last expected %0b actual %0b", $time, e.last, rsp_last);
            mismatches++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cnt <= 0;
      end else begin
         idle_cnt <= idle_cnt + 1;
         if (idle_cnt == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_pixel  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_MODE;
      csr_wdata  = '0;
      pixels_sent = 0;
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      src_row    = 0;
      src_col    = 0;
      cur_mode   = MODE_BICUBIC;
      cur_width  = 11'd1024;
      cur_height = 11'd1024;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_modes_extremes();
      test_dim_limits();
      test_random_frames();
      wait_drained();
      if (mismatches == 0 && upscaled_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
